// File: sv/aet_pkg.sv
// Shared types and constants of the arithmetic expression tokenizer.
`default_nettype none

package aet_pkg;

  // Datapath sizes
  localparam int VALUE_BITS      = 32;
  localparam int POSITION_BITS   = 16;
  localparam int KEYWORD_LETTERS = 4;
  localparam int LETTER_IDX_W    = $clog2(KEYWORD_LETTERS);
  localparam int LETTER_CNT_W    = $clog2(KEYWORD_LETTERS + 2);
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Keyword spellings, first letter in the top byte
  localparam logic [23:0] KW_SIN  = "sin";
  localparam logic [23:0] KW_COS  = "cos";
  localparam logic [23:0] KW_TAN  = "tan";
  localparam logic [23:0] KW_LOG  = "log";
  localparam logic [31:0] KW_SQRT = "sqrt";

  typedef enum logic [3:0] {
    TK_ADD, TK_SUB, TK_NEG, TK_MULT, TK_DIV, TK_EXP, TK_LPAREN, TK_RPAREN,
    TK_DOT, TK_INT, TK_SIN, TK_COS, TK_TAN, TK_LOG, TK_SQRT
  } kind_t;

  typedef enum logic {
    ERR_CHAR,
    ERR_IDENT
  } err_t;

  typedef logic [KEYWORD_LETTERS-1:0][7:0] letters_t;
  typedef logic [LETTER_CNT_W-1:0]         lcnt_t;

  // One result word
  typedef struct packed {
    logic                     is_error;
    kind_t                    token_kind;
    err_t                     error_kind;
    logic [VALUE_BITS-1:0]    int_value;
    logic                     int_overflow;
    logic [7:0]               bad_char;
    logic [POSITION_BITS-1:0] start_position;
    logic                     last_of_run;
  } res_t;

  // Results produced by one character, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

`default_nettype wire

// File: sv/aet_if.sv
// Handshake channels for characters in and result words out.
`default_nettype none

interface aet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface aet_out_if import aet_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     is_error;
  logic [3:0]               token_kind;
  logic                     error_kind;
  logic [VALUE_BITS-1:0]    int_value;
  logic                     int_overflow;
  logic [7:0]               bad_char;
  logic [POSITION_BITS-1:0] start_position;
  logic                     last_of_run;

  modport source (
    output valid, output is_error, output token_kind, output error_kind,
    output int_value, output int_overflow, output bad_char,
    output start_position, output last_of_run, input ready
  );
  modport sink (
    input valid, input is_error, input token_kind, input error_kind,
    input int_value, input int_overflow, input bad_char,
    input start_position, input last_of_run, output ready
  );
endinterface

`default_nettype wire

// File: sv/aet_lexer_core.sv
// Input register, scanner state and per-character token logic.
`default_nettype none

module aet_lexer_core import aet_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  aet_in_if.sink    in_chan,
  input  wire logic room,
  output push_t     push
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_WORD
  } mode_t;

  typedef struct packed {
    logic hit;
    logic set_cls;
    logic operand;
    res_t res;
  } flush_t;

  localparam logic [VALUE_BITS+3:0] VAL_MAX_W = {4'b0, {VALUE_BITS{1'b1}}};

  // Input register
  logic       in_valid_r;
  logic [7:0] char_r;
  logic       end_r;
  logic       fire;

  // Scanner state
  mode_t                    mode_r, mode_nxt;
  logic [VALUE_BITS-1:0]    acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  letters_t                 letters_r, letters_nxt;
  lcnt_t                    lcnt_r, lcnt_nxt;
  logic                     operand_r, operand_nxt;

  logic   is_digit, is_alpha, done;
  logic [1:0] nres;
  res_t   res0, res1, tok;
  flush_t fl_a, fl_b;

  // Multiply by ten and add a digit, saturating at the top of the range
  function automatic logic [VALUE_BITS:0] accumulate(logic [VALUE_BITS-1:0] a, logic o,
                                                     logic [3:0] d);
    logic [VALUE_BITS+3:0] wide;
    logic [VALUE_BITS+3:0] t;
    wide = {4'b0, a};
    t = (wide << 3) + (wide << 1) + {{VALUE_BITS{1'b0}}, d};
    if (t > VAL_MAX_W) begin
      return {1'b1, {VALUE_BITS{1'b1}}};
    end
    return {o, t[VALUE_BITS-1:0]};
  endfunction

  // Turn a pending integer or word into its result
  function automatic flush_t do_flush(mode_t m, logic [VALUE_BITS-1:0] a, logic o,
                                      logic [POSITION_BITS-1:0] s, letters_t b, lcnt_t n);
    flush_t f;
    f = '0;
    f.res.start_position = s;
    if (m == MODE_INT) begin
      f.hit                = 1'b1;
      f.set_cls            = 1'b1;
      f.operand            = 1'b1;
      f.res.token_kind     = TK_INT;
      f.res.int_value      = a;
      f.res.int_overflow   = o;
    end else if (m == MODE_WORD) begin
      f.hit     = 1'b1;
      f.set_cls = 1'b1;
      if (n == lcnt_t'(3) && {b[0], b[1], b[2]} == KW_SIN) begin
        f.res.token_kind = TK_SIN;
      end else if (n == lcnt_t'(3) && {b[0], b[1], b[2]} == KW_COS) begin
        f.res.token_kind = TK_COS;
      end else if (n == lcnt_t'(3) && {b[0], b[1], b[2]} == KW_TAN) begin
        f.res.token_kind = TK_TAN;
      end else if (n == lcnt_t'(3) && {b[0], b[1], b[2]} == KW_LOG) begin
        f.res.token_kind = TK_LOG;
      end else if (n == lcnt_t'(4) && {b[0], b[1], b[2], b[3]} == KW_SQRT) begin
        f.res.token_kind = TK_SQRT;
      end else begin
        // unknown identifier leaves the operand class alone
        f.set_cls        = 1'b0;
        f.res.is_error   = 1'b1;
        f.res.error_kind = ERR_IDENT;
      end
    end
    return f;
  endfunction

  assign fire          = in_valid_r && room;
  assign in_chan.ready = !in_valid_r || fire;

  // Hold one character until the queue has space for its results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      char_r <= in_chan.char_code;
      end_r  <= in_chan.end_of_text;
    end
  end

  assign is_digit = (char_r >= "0") && (char_r <= "9");
  assign is_alpha = ((char_r >= "a") && (char_r <= "z")) ||
                    ((char_r >= "A") && (char_r <= "Z"));

  // Scan one character
  always_comb begin
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    start_nxt   = start_r;
    pos_nxt     = pos_r + POSITION_BITS'(1);
    letters_nxt = letters_r;
    lcnt_nxt    = lcnt_r;
    operand_nxt = operand_r;
    done        = 1'b0;
    nres        = 2'd0;
    res0        = '0;
    res1        = '0;
    tok         = '0;
    fl_a        = '0;
    fl_b        = '0;

    // continue or end a pending integer or word
    unique case (mode_r)
      MODE_INT: begin
        if (is_digit) begin
          {ovf_nxt, acc_nxt} = accumulate(acc_r, ovf_r, char_r[3:0]);
          done = 1'b1;
        end else begin
          fl_a     = do_flush(mode_r, acc_r, ovf_r, start_r, letters_r, lcnt_r);
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (is_alpha) begin
          if (lcnt_r < lcnt_t'(KEYWORD_LETTERS)) begin
            letters_nxt[lcnt_r[LETTER_IDX_W-1:0]] = char_r;
            lcnt_nxt = lcnt_r + lcnt_t'(1);
          end else begin
            lcnt_nxt = lcnt_t'(KEYWORD_LETTERS + 1);
          end
          done = 1'b1;
        end else begin
          fl_a     = do_flush(mode_r, acc_r, ovf_r, start_r, letters_r, lcnt_r);
          mode_nxt = MODE_IDLE;
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
    if (fl_a.hit) begin
      res0 = fl_a.res;
      nres = 2'd1;
    end
    if (fl_a.set_cls) begin
      operand_nxt = fl_a.operand;
    end

    // the character itself
    if (!done) begin
      tok.start_position = pos_r;
      case (char_r) inside
        CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
        end
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_LPAREN, CH_RPAREN, CH_DOT: begin
          case (char_r)
            CH_PLUS:   tok.token_kind = TK_ADD;
            CH_MINUS:  tok.token_kind = operand_nxt ? TK_SUB : TK_NEG;
            CH_STAR:   tok.token_kind = TK_MULT;
            CH_SLASH:  tok.token_kind = TK_DIV;
            CH_CARET:  tok.token_kind = TK_EXP;
            CH_LPAREN: tok.token_kind = TK_LPAREN;
            CH_RPAREN: tok.token_kind = TK_RPAREN;
            default:   tok.token_kind = TK_DOT;
          endcase
          operand_nxt = (char_r == CH_RPAREN);
          if (nres == 2'd0) res0 = tok;
          else              res1 = tok;
          nres = nres + 2'd1;
        end
        default: begin
          if (is_digit) begin
            mode_nxt  = MODE_INT;
            start_nxt = pos_r;
            acc_nxt   = {{(VALUE_BITS-4){1'b0}}, char_r[3:0]};
            ovf_nxt   = 1'b0;
          end else if (is_alpha) begin
            mode_nxt       = MODE_WORD;
            start_nxt      = pos_r;
            letters_nxt[0] = char_r;
            lcnt_nxt       = lcnt_t'(1);
          end else begin
            tok.is_error   = 1'b1;
            tok.error_kind = ERR_CHAR;
            tok.bad_char   = char_r;
            if (nres == 2'd0) res0 = tok;
            else              res1 = tok;
            nres = nres + 2'd1;
          end
        end
      endcase
    end

    // end of text: flush and start a fresh text
    if (end_r) begin
      fl_b = do_flush(mode_nxt, acc_nxt, ovf_nxt, start_nxt, letters_nxt, lcnt_nxt);
      if (fl_b.hit) begin
        if (nres == 2'd0) res0 = fl_b.res;
        else              res1 = fl_b.res;
        nres = nres + 2'd1;
      end
      mode_nxt    = MODE_IDLE;
      pos_nxt     = '0;
      operand_nxt = 1'b0;
    end

    // mark the final result of this character
    if (nres == 2'd1) res0.last_of_run = 1'b1;
    if (nres == 2'd2) res1.last_of_run = 1'b1;
  end

  // Advance scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      start_r   <= '0;
      pos_r     <= '0;
      lcnt_r    <= '0;
      operand_r <= 1'b0;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      acc_r     <= acc_nxt;
      ovf_r     <= ovf_nxt;
      start_r   <= start_nxt;
      pos_r     <= pos_nxt;
      lcnt_r    <= lcnt_nxt;
      operand_r <= operand_nxt;
    end
    if (fire) begin
      letters_r <= letters_nxt;
    end
  end

  assign push.count  = fire ? nres : 2'd0;
  assign push.first  = res0;
  assign push.second = res1;

endmodule

`default_nettype wire

// File: sv/aet_result_fifo.sv
// Result queue: takes up to two words a cycle, gives one a cycle while the receiver is ready.
`default_nettype none

module aet_result_fifo import aet_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  aet_out_if.source  out_chan
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt;
  logic [FIFO_PTR_W-1:0] rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  res_t                  head;

  assign pop  = out_chan.valid && out_chan.ready;
  assign room = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  // Pointer and fill count
  always_comb begin
    wr_nxt  = wr_r + FIFO_PTR_W'(push.count);
    rd_nxt  = rd_r + FIFO_PTR_W'(pop);
    cnt_nxt = cnt_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store incoming words in order
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_r + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  // Drive the head word
  assign head                    = mem[rd_r];
  assign out_chan.valid          = cnt_r != '0;
  assign out_chan.is_error       = head.is_error;
  assign out_chan.token_kind     = head.token_kind;
  assign out_chan.error_kind     = head.error_kind;
  assign out_chan.int_value      = head.int_value;
  assign out_chan.int_overflow   = head.int_overflow;
  assign out_chan.bad_char       = head.bad_char;
  assign out_chan.start_position = head.start_position;
  assign out_chan.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// File: sv/arithmetic_expression_tokenizer.sv
// Top level of the arithmetic expression tokenizer.
// An accepted character waits in the input register until the result queue has room;
//   its results are then written to the queue, and the head word is offered from there.
// Throughput: one character per cycle while the queue has room; a character with two
//   results gives them out in turn through the single read port of the four-word result queue.
// Reset: synchronous active-low rst_n empties the queue and returns the scanner to idle.
`default_nettype none

module arithmetic_expression_tokenizer import aet_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  aet_in_if.sink    in_chan,
  aet_out_if.source out_chan
);

  push_t push;
  logic  room;

  // Scanner
  aet_lexer_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  // Result queue
  aet_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// File: sv/aet_checker.sv
// Port-level checks of the tokenizer, bound to the top level.
`default_nettype none

module aet_checker import aet_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     out_last,
  input wire logic [POSITION_BITS-1:0] out_start
);

  // Input stalls only while a result word waits
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result word pending");

  // Second word of a character follows directly
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("result run ended without a last word");

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start) && $stable(out_last))
    else $error("stalled result word changed");

endmodule

bind arithmetic_expression_tokenizer aet_checker u_aet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_last  (out_chan.last_of_run),
  .out_start (out_chan.start_position)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the arithmetic expression tokenizer.
`timescale 1ns / 1ps

module testbench;
  import aet_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_INT, SCAN_WORD} scan_t;
  typedef enum logic [1:0] {PREV_NONE, PREV_OTHER, PREV_OPERAND} prev_t;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  // Predict result words from accepted characters and check the words that come out
  class token_scoreboard;
    scan_t                    scan;
    prev_t                    prev_class;
    logic [VALUE_BITS-1:0]    acc;
    logic                     acc_ovf;
    logic [POSITION_BITS-1:0] tok_start;
    logic [POSITION_BITS-1:0] next_pos;
    logic [7:0]               letters[KEYWORD_LETTERS];
    int                       letter_cnt;
    res_t                     step_words[$];
    res_t                     expected_words[$];
    int                       fail_count;
    int                       n_checked, n_ints, n_keywords, n_errors, n_saturated;

    function new();
      scan       = SCAN_IDLE;
      prev_class = PREV_NONE;
      acc        = '0;
      acc_ovf    = 1'b0;
      tok_start  = '0;
      next_pos   = '0;
      letter_cnt = 0;
      fail_count = 0;
      n_checked  = 0;
      n_ints     = 0;
      n_keywords = 0;
      n_errors   = 0;
      n_saturated = 0;
    endfunction

    function void add_word(logic err, kind_t k, err_t e, logic [VALUE_BITS-1:0] v,
                           logic o, logic [7:0] b, logic [POSITION_BITS-1:0] s);
      res_t w;
      w = '0;
      w.is_error       = err;
      w.token_kind     = k;
      w.error_kind     = e;
      w.int_value      = v;
      w.int_overflow   = o;
      w.bad_char       = b;
      w.start_position = s;
      step_words.push_back(w);
    endfunction

    function void add_token(kind_t k, logic [VALUE_BITS-1:0] v, logic o,
                            logic [POSITION_BITS-1:0] s);
      prev_class = (k == TK_INT || k == TK_RPAREN) ? PREV_OPERAND : PREV_OTHER;
      add_word(1'b0, k, ERR_CHAR, v, o, 8'h00, s);
    endfunction

    // Multiply by ten and add, saturating at the top of the range
    function void add_digit(logic [7:0] c);
      longint unsigned d;
      d = longint'(c - "0");
      if (longint'(acc) > (longint'(VALUE_MAX) - d) / 10) begin
        acc     = VALUE_MAX;
        acc_ovf = 1'b1;
      end else begin
        acc = VALUE_BITS'(acc * 10 + d);
      end
    endfunction

    // Keep the first letters; a longer word pins the count one past the buffer
    function void add_letter(logic [7:0] c);
      if (letter_cnt < KEYWORD_LETTERS) begin
        letters[letter_cnt] = c;
        letter_cnt++;
      end else begin
        letter_cnt = KEYWORD_LETTERS + 1;
      end
    endfunction

    function bit spelled(logic [31:0] kw, int len);
      if (letter_cnt != len || len > KEYWORD_LETTERS) return 1'b0;
      for (int i = 0; i < len; i++)
        if (letters[i] != kw[8*(len-1-i) +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    // Emit the pending integer or word, if any
    function void close_pending();
      scan_t m;
      m = scan;
      scan = SCAN_IDLE;
      if (m == SCAN_INT) add_token(TK_INT, acc, acc_ovf, tok_start);
      else if (m == SCAN_WORD) begin
        if (spelled(32'(KW_SIN), 3))       add_token(TK_SIN, '0, 1'b0, tok_start);
        else if (spelled(32'(KW_COS), 3))  add_token(TK_COS, '0, 1'b0, tok_start);
        else if (spelled(32'(KW_TAN), 3))  add_token(TK_TAN, '0, 1'b0, tok_start);
        else if (spelled(32'(KW_LOG), 3))  add_token(TK_LOG, '0, 1'b0, tok_start);
        else if (spelled(KW_SQRT, 4))      add_token(TK_SQRT, '0, 1'b0, tok_start);
        else add_word(1'b1, TK_ADD, ERR_IDENT, '0, 1'b0, 8'h00, tok_start);
      end
    endfunction

    // Handle a character with nothing pending
    function void start_fresh(logic [7:0] c, logic [POSITION_BITS-1:0] p);
      case (c)
        CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
        CH_PLUS:   add_token(TK_ADD, '0, 1'b0, p);
        CH_MINUS:  add_token((prev_class == PREV_OPERAND) ? TK_SUB : TK_NEG, '0, 1'b0, p);
        CH_STAR:   add_token(TK_MULT, '0, 1'b0, p);
        CH_SLASH:  add_token(TK_DIV, '0, 1'b0, p);
        CH_CARET:  add_token(TK_EXP, '0, 1'b0, p);
        CH_LPAREN: add_token(TK_LPAREN, '0, 1'b0, p);
        CH_RPAREN: add_token(TK_RPAREN, '0, 1'b0, p);
        CH_DOT:    add_token(TK_DOT, '0, 1'b0, p);
        default: begin
          if (c >= "0" && c <= "9") begin
            scan      = SCAN_INT;
            tok_start = p;
            acc       = '0;
            acc_ovf   = 1'b0;
            add_digit(c);
          end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            scan       = SCAN_WORD;
            tok_start  = p;
            letter_cnt = 0;
            add_letter(c);
          end else begin
            add_word(1'b1, TK_ADD, ERR_CHAR, '0, 1'b0, c, p);
          end
        end
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic eot);
      logic [POSITION_BITS-1:0] p;
      bit                       done;
      int                       last;
      p        = next_pos;
      next_pos = p + 1'b1;
      done     = 1'b0;
      step_words.delete();
      if (scan == SCAN_INT) begin
        if (c >= "0" && c <= "9") begin
          add_digit(c);
          done = 1'b1;
        end else close_pending();
      end else if (scan == SCAN_WORD) begin
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
          add_letter(c);
          done = 1'b1;
        end else close_pending();
      end
      if (!done) start_fresh(c, p);
      if (eot) begin
        close_pending();
        next_pos   = '0;
        prev_class = PREV_NONE;
      end
      last = step_words.size() - 1;
      if (last >= 0) step_words[last].last_of_run = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void match_field(string name, logic [VALUE_BITS-1:0] want,
                              logic [VALUE_BITS-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        fail_count++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: kind %0d error %0b start %0d",
               got.token_kind, got.is_error, got.start_position);
        fail_count++;
        return;
      end
      want = expected_words.pop_front();
      n_checked++;
      if (want.is_error) n_errors++;
      else if (want.token_kind == TK_INT) n_ints++;
      else if (want.token_kind >= TK_SIN) n_keywords++;
      if (want.int_overflow) n_saturated++;
      match_field("is_error", want.is_error, got.is_error);
      match_field("token_kind", want.token_kind, got.token_kind);
      match_field("error_kind", want.error_kind, got.error_kind);
      match_field("int_value", want.int_value, got.int_value);
      match_field("int_overflow", want.int_overflow, got.int_overflow);
      match_field("bad_char", want.bad_char, got.bad_char);
      match_field("start_position", want.start_position, got.start_position);
      match_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  aet_in_if  in_chan();
  aet_out_if out_chan();

  arithmetic_expression_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  token_scoreboard sb = new();

  int         in_idle_pct  = 29;
  int         out_idle_pct = 29;
  int         hold_request = 0;
  int         chars_sent   = 0;
  int         texts_sent   = 0;
  logic [7:0] text_buf[$];

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAIL arithmetic_expression_tokenizer");
    $finish;
  end

  // Receiver: random ready, with an occasional long hold-off
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got = '0;
      got.is_error       = out_chan.is_error;
      got.token_kind     = kind_t'(out_chan.token_kind);
      got.error_kind     = err_t'(out_chan.error_kind);
      got.int_value      = out_chan.int_value;
      got.int_overflow   = out_chan.int_overflow;
      got.bad_char       = out_chan.bad_char;
      got.start_position = out_chan.start_position;
      got.last_of_run    = out_chan.last_of_run;
      sb.check_word(got);
    end
  end

  // Offer one character, with random gaps first; entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.char_code   <= c;
    in_chan.end_of_text <= eot;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_char(c, eot);
    chars_sent++;
    @(negedge clk);
  endtask

  // Send the buffered text, marking its last character as the end
  task automatic send_text();
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send_char(text_buf[i], i == n - 1);
    text_buf.delete();
    texts_sent++;
  endtask

  function automatic void load_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // Append one random lexeme, mostly well formed
  function automatic void add_lexeme();
    string       ops;
    string       odd;
    string       kws[5];
    int unsigned v;
    int          pick, len;
    ops    = "+-*/^().--";
    odd    = "!#$%&,:;<=>?@[]_{}|~`'\\\"";
    kws[0] = "sin"; kws[1] = "cos"; kws[2] = "tan"; kws[3] = "log"; kws[4] = "sqrt";
    pick   = $urandom_range(99);
    if (pick < 30) begin
      len = $urandom_range(99);
      if (len < 70) begin
        v = $urandom_range(999);
        load_str($sformatf("%0d", v));
      end else if (len < 85) begin
        v = $urandom();
        load_str($sformatf("%0d", v));
      end else if (len < 90) load_str("4294967295");
      else if (len < 95) load_str("4294967296");
      else repeat ($urandom_range(11, 14)) text_buf.push_back(8'("0" + $urandom_range(9)));
    end else if (pick < 55) begin
      text_buf.push_back(ops[$urandom_range(ops.len() - 1)]);
    end else if (pick < 70) begin
      load_str(kws[$urandom_range(4)]);
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: text_buf.push_back(CH_SPACE);
        1: text_buf.push_back(CH_TAB);
        2: text_buf.push_back(CH_LF);
        default: text_buf.push_back(CH_CR);
      endcase
    end else if (pick < 88) begin
      if ($urandom_range(3) == 0) load_str(kws[$urandom_range(4)]);
      repeat ($urandom_range(1, 7)) begin
        if ($urandom_range(1)) text_buf.push_back(8'("a" + $urandom_range(25)));
        else text_buf.push_back(8'("A" + $urandom_range(25)));
      end
    end else if (pick < 94) begin
      if ($urandom_range(3) == 0) text_buf.push_back(8'($urandom_range(31)));
      else text_buf.push_back(odd[$urandom_range(odd.len() - 1)]);
    end else begin
      text_buf.push_back(8'($urandom_range(255)));
    end
    // Separate lexemes with a blank now and then
    if ($urandom_range(99) < 40) text_buf.push_back(CH_SPACE);
  endfunction

  // Stimulus
  initial begin : stimulus
    int drain_wait;
    int random_chars;
    int random_texts;

    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.char_code   = 8'h00;
    in_chan.end_of_text = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: negation at the start, saturation, subtraction after ) and after an integer
    load_str("-4294967296)-7-(sqrt^");
    send_text();
    // Directed: NUL, upper-case word, two words from one character, top byte, flush at end
    text_buf.push_back(8'h00);
    load_str("Tan*.");
    text_buf.push_back(8'hFF);
    load_str(" log");
    send_text();
    // Directed: a lone trailing blank gives nothing
    load_str(" ");
    send_text();

    // Random texts
    random_chars = 0;
    random_texts = 0;
    while (random_chars < 1650) begin
      in_idle_pct  = (random_texts >= 40 && random_texts < 80) ? 0 : 29;
      out_idle_pct = in_idle_pct;
      if (random_texts == 25 || random_texts == 110) hold_request = 250;
      repeat ($urandom_range(1, 12)) add_lexeme();
      random_chars += text_buf.size();
      send_text();
      random_texts++;
    end
    in_chan.valid <= 1'b0;

    // Drain, then allow a few more cycles for stray words
    drain_wait = 0;
    while (sb.expected_words.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (16) @(posedge clk);
    if (sb.expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", sb.expected_words.size());
      sb.fail_count++;
    end

    $display("Sent %0d characters in %0d texts, gap-free stretch and long output hold-off included.",
             chars_sent, texts_sent);
    $display("Checked %0d words: %0d integers (%0d saturated), %0d keywords, %0d errors.",
             sb.n_checked, sb.n_ints, sb.n_saturated, sb.n_keywords, sb.n_errors);
    if (sb.fail_count == 0) begin
      $display("PASS arithmetic_expression_tokenizer");
    end else begin
      $display("FAIL arithmetic_expression_tokenizer");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/aet_pkg.sv
sv/aet_if.sv
sv/aet_lexer_core.sv
sv/aet_result_fifo.sv
sv/arithmetic_expression_tokenizer.sv
sv/aet_checker.sv
verif/testbench.sv
